### design/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round tables for the MD5 digest engine.
// ----------------------------------------------------------------------------
`default_nettype none

package md5_pkg;

   localparam int RoundCountDefault = 64;

   typedef struct packed {
      logic        last;
      logic [2:0]  byte_count;
      logic [31:0] data_word;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_d;
      logic [31:0] digest_c;
      logic [31:0] digest_b;
      logic [31:0] digest_a;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LOAD,
      ST_ROUND,
      ST_ADD,
      ST_OUT
   } state_type;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;
   localparam logic [31:0] PAD_WORD = 32'h00000080;

   // per-round additive constant
   function automatic logic [31:0] add_const(input logic [5:0] r);
      logic [31:0] k;
      unique case (r)
         6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   // rotate amount by stage and low round bits
   function automatic logic [4:0] rot_amount(input logic [5:0] r);
      logic [4:0] s;
      unique case ({r[5:4], r[1:0]})
         4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
         4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
         4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
         4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
      endcase
      return s;
   endfunction

   // message word index for a round, all mod 16 via truncation
   function automatic logic [3:0] word_index(input logic [5:0] r);
      logic [3:0] g;
      unique case (r[5:4])
         2'd0: g = r[3:0];
         2'd1: g = 4'(5 * r[3:0] + 1);
         2'd2: g = 4'(3 * r[3:0] + 5);
         default: g = 4'(7 * r[3:0]);
      endcase
      return g;
   endfunction

endpackage

`default_nettype wire

### design/md5_round.sv
// ----------------------------------------------------------------------------
// md5_round
// One MD5 round step: boolean function, four-way add, rotate, final add.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_round (
   input  wire logic [5:0]   round_idx,
   input  wire logic [31:0]  a_in,
   input  wire logic [31:0]  b_in,
   input  wire logic [31:0]  c_in,
   input  wire logic [31:0]  d_in,
   input  wire logic [31:0]  msg_word,
   output logic      [31:0]  b_out
);

   logic [31:0] f_val;
   logic [31:0] sum_val;
   logic [63:0] rot_wide;
   logic [4:0]  rot_n;

   // stage boolean function
   always_comb begin
      unique case (round_idx[5:4])
         2'd0: f_val = (b_in & c_in) | (~b_in & d_in);
         2'd1: f_val = (b_in & d_in) | (c_in & ~d_in);
         2'd2: f_val = b_in ^ c_in ^ d_in;
         default: f_val = c_in ^ (b_in | ~d_in);
      endcase
   end

   // add, rotate left, add
   always_comb begin
      rot_n    = md5_pkg::rot_amount(round_idx);
      sum_val  = a_in + f_val + md5_pkg::add_const(round_idx) + msg_word;
      rot_wide = {sum_val, sum_val} << rot_n;
      b_out    = b_in + rot_wide[63:32];
   end

endmodule

`default_nettype wire

### design/md5_digest_engine_core.sv
// ----------------------------------------------------------------------------
// md5_digest_engine_core
// Streaming MD5 digest engine with one shared round unit.
// ----------------------------------------------------------------------------
// Each request is one little-endian message word; the word marked last
// closes the message and produces one response with the digest words A-D.
// A non-last word that does not complete a block is simply stored. A word that
// completes a 16-word block starts a compression (load, 64 rounds through the
// single round unit, chaining add). A last word additionally fills padding
// one word per cycle and runs one or two compressions before the response
// appears; the response register then holds until taken. Requests are stalled
// from any word that starts a compression or padding until the core is idle again.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_digest_engine_core #(
   parameter int ROUND_COUNT = md5_pkg::RoundCountDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire md5_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output md5_pkg::rsp_type      rsp_data
);

   localparam int RW = $clog2(ROUND_COUNT);

   md5_pkg::state_type state_ff, state_in;
   logic [31:0] buf_mem [16];
   logic [31:0] ch_ff [4];
   logic [31:0] ch_in [4];
   logic [31:0] wk_ff [4];
   logic [31:0] wk_in [4];
   logic [3:0]  pos_ff, pos_in;
   logic [RW-1:0] rnd_ff, rnd_in;
   logic [63:0] len_ff, len_in;
   logic        fin_ff, fin_in;       // message ending, padding pending
   logic        pad80_ff, pad80_in;   // 0x80 word still to place
   logic        lenw_ff, lenw_in;     // length words placed
   logic        lenlo_ff, lenlo_in;   // low length word just placed
   logic        wr_en;
   logic [31:0] wr_data;
   logic [31:0] msg_q;
   logic [31:0] round_b;
   logic        req_fire;
   logic [2:0]  cnt;
   logic [31:0] last_word;
   logic [5:0]  ridx;
   logic [3:0]  rd_idx;

   assign req_fire = req_valid && !req_stall;
   assign ridx     = 6'(rnd_ff);

   // block buffer, one write and one registered read a cycle
   assign rd_idx = (state_ff == md5_pkg::ST_ROUND) ? md5_pkg::word_index(6'(rnd_ff + 1'b1))
                                                   : md5_pkg::word_index(6'd0);
   always_ff @(posedge clock) begin
      if (wr_en) begin
         buf_mem[pos_ff] <= wr_data;
      end
      msg_q <= buf_mem[rd_idx];
   end

   md5_round u_round (
      .round_idx (ridx),
      .a_in      (wk_ff[0]),
      .b_in      (wk_ff[1]),
      .c_in      (wk_ff[2]),
      .d_in      (wk_ff[3]),
      .msg_word  (msg_q),
      .b_out     (round_b)
   );

   // last word masking and pad byte
   always_comb begin
      cnt = (req_data.byte_count > 3'd4) ? 3'd4 : req_data.byte_count;
      unique case (cnt)
         3'd0: last_word = md5_pkg::PAD_WORD;
         3'd1: last_word = {16'h0, 8'h80, req_data.data_word[7:0]};
         3'd2: last_word = {8'h0, 8'h80, req_data.data_word[15:0]};
         3'd3: last_word = {8'h80, req_data.data_word[23:0]};
         default: last_word = req_data.data_word;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         md5_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (pos_ff == 4'd15) state_in = md5_pkg::ST_LOAD;
               else if (req_data.last) state_in = md5_pkg::ST_PAD;
            end
         end
         md5_pkg::ST_PAD: begin
            if (pos_ff == 4'd15) state_in = md5_pkg::ST_LOAD;
         end
         md5_pkg::ST_LOAD:  state_in = md5_pkg::ST_ROUND;
         md5_pkg::ST_ROUND: begin
            if (rnd_ff == RW'(ROUND_COUNT - 1)) state_in = md5_pkg::ST_ADD;
         end
         md5_pkg::ST_ADD: begin
            if (!fin_ff) state_in = md5_pkg::ST_IDLE;
            else if (lenw_ff) state_in = md5_pkg::ST_OUT;
            else state_in = md5_pkg::ST_PAD;
         end
         md5_pkg::ST_OUT: begin
            if (!rsp_stall) state_in = md5_pkg::ST_IDLE;
         end
         default: state_in = md5_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_stall = (state_ff != md5_pkg::ST_IDLE);
      rsp_valid = (state_ff == md5_pkg::ST_OUT);
      rsp_data.digest_a = ch_ff[0];
      rsp_data.digest_b = ch_ff[1];
      rsp_data.digest_c = ch_ff[2];
      rsp_data.digest_d = ch_ff[3];
      wr_en = 1'b0;
      wr_data = req_data.data_word;
      pos_in = pos_ff; rnd_in = rnd_ff; len_in = len_ff;
      fin_in = fin_ff; pad80_in = pad80_ff; lenw_in = lenw_ff;
      lenlo_in = lenlo_ff;
      ch_in = ch_ff; wk_in = wk_ff;
      unique case (state_ff)
         md5_pkg::ST_IDLE: begin
            if (req_fire) begin
               wr_en  = 1'b1;
               pos_in = pos_ff + 4'd1;
               if (req_data.last) begin
                  wr_data  = last_word;
                  len_in   = len_ff + 64'({cnt, 3'b000});
                  fin_in   = 1'b1;
                  pad80_in = (cnt == 3'd4);
                  lenw_in  = 1'b0;
               end else begin
                  len_in = len_ff + 64'd32;
               end
            end
         end
         md5_pkg::ST_PAD: begin
            wr_en    = 1'b1;
            pos_in   = pos_ff + 4'd1;
            lenlo_in = !pad80_ff && (pos_ff == 4'd14);
            if (pad80_ff) begin
               wr_data  = md5_pkg::PAD_WORD;
               pad80_in = 1'b0;
            end else if (pos_ff == 4'd14) wr_data = len_ff[31:0];
            else if (pos_ff == 4'd15 && lenlo_ff) begin
               wr_data = len_ff[63:32];
               lenw_in = 1'b1;
            end else wr_data = 32'h0;
            // 0x80 landing at 15 leaves no room for length
            if (pad80_ff && pos_ff == 4'd15) lenw_in = 1'b0;
         end
         md5_pkg::ST_LOAD: begin
            wk_in  = ch_ff;
            rnd_in = '0;
         end
         md5_pkg::ST_ROUND: begin
            wk_in[0] = wk_ff[3];
            wk_in[3] = wk_ff[2];
            wk_in[2] = wk_ff[1];
            wk_in[1] = round_b;
            rnd_in   = rnd_ff + 1'b1;
         end
         md5_pkg::ST_ADD: begin
            for (int i = 0; i < 4; i++) ch_in[i] = ch_ff[i] + wk_ff[i];
         end
         md5_pkg::ST_OUT: begin
            if (!rsp_stall) begin
               ch_in[0] = md5_pkg::INIT_A; ch_in[1] = md5_pkg::INIT_B;
               ch_in[2] = md5_pkg::INIT_C; ch_in[3] = md5_pkg::INIT_D;
               len_in = '0; fin_in = 1'b0; pos_in = '0;
            end
         end
         default: ;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= md5_pkg::ST_IDLE;
         ch_ff[0] <= md5_pkg::INIT_A; ch_ff[1] <= md5_pkg::INIT_B;
         ch_ff[2] <= md5_pkg::INIT_C; ch_ff[3] <= md5_pkg::INIT_D;
         wk_ff    <= '{default: '0};
         pos_ff   <= '0;
         rnd_ff   <= '0;
         len_ff   <= '0;
         fin_ff   <= 1'b0;
         pad80_ff <= 1'b0;
         lenw_ff  <= 1'b0;
         lenlo_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
         wk_ff    <= wk_in;
         pos_ff   <= pos_in;
         rnd_ff   <= rnd_in;
         len_ff   <= len_in;
         fin_ff   <= fin_in;
         pad80_ff <= pad80_in;
         lenw_ff  <= lenw_in;
         lenlo_ff <= lenlo_in;
      end
   end

endmodule

`default_nettype wire

### design/md5_checker.sv
// ----------------------------------------------------------------------------
// md5_checker
// Port-level checks of the MD5 engine handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire md5_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire md5_pkg::rsp_type rsp_data
);

   // a pending response holds its digest
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   // no new request while a digest waits
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while response pending");

   // last request never answered in the next cycle
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.last |=> !rsp_valid)
      else $error("digest too early");

   // out of reset idle
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("not idle after reset");

endmodule

bind md5_digest_engine_core md5_checker u_md5_checker (.*);

`default_nettype wire
